// ===== design/shifted_operand_multiply_unit_defines.svh =====
// Assertion helpers used by somu_back.
`ifndef SHIFTED_OPERAND_MULTIPLY_UNIT_DEFINES_SVH
`define SHIFTED_OPERAND_MULTIPLY_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define SOMU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SOMU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/somu_pkg.sv =====
package somu_pkg;

  localparam int NumRegs = 16;
  localparam int RegAw   = $clog2(NumRegs);
  localparam int DataW   = 32;
  localparam int QDepth  = 2;
  localparam int QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW   = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_MUL_REG = 2'd2,
    REQ_MUL_IMM = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_e;

  // Decoded request as it travels from front to back.
  typedef struct packed {
    req_e              kind;
    logic [RegAw-1:0]  dest;
    logic [RegAw-1:0]  addr_n;     // Rn, or reg_index for a read or a write
    logic [RegAw-1:0]  addr_m;
    logic [RegAw-1:0]  addr_s;
    logic              amt_from_reg;
    shift_e            sh;
    logic [4:0]        imm_amt;
    logic [DataW-1:0]  imm_val;    // rotated immediate, or the write value
  } op_t;

  function automatic logic [DataW-1:0] rot_imm(logic [7:0] imm, logic [3:0] rot);
    logic [2*DataW-1:0] dbl;
    dbl = {24'd0, imm, 24'd0, imm} >> {rot, 1'b0};
    return dbl[DataW-1:0];
  endfunction

  // Register-amount shifts of 32 or more saturate; ROR wraps.
  function automatic logic [DataW-1:0] shift_operand(logic [DataW-1:0] x, shift_e sh,
                                                     logic [7:0] amt);
    logic               big;
    logic [4:0]         s;
    logic [2*DataW-1:0] dbl;
    logic [DataW-1:0]   res;
    big = |amt[7:5];
    s   = amt[4:0];
    dbl = {x, x} >> s;
    case (sh)
      SH_LSL:  res = big ? '0 : (x << s);
      SH_LSR:  res = big ? '0 : (x >> s);
      SH_ASR:  res = big ? {DataW{x[DataW-1]}} : DataW'($signed(x) >>> s);
      SH_ROR:  res = dbl[DataW-1:0];
      default: res = x;
    endcase
    return res;
  endfunction

endpackage

// ===== design/somu_front.sv =====
module somu_front (
  input  logic [1:0]           req_type_i,
  input  logic [31:0]          instr_i,
  input  logic [3:0]           reg_index_i,
  input  logic [31:0]          reg_value_i,
  output somu_pkg::op_t        op_o
);

  somu_pkg::req_e kind;

  assign kind = somu_pkg::req_e'(req_type_i);

  always_comb begin
    op_o.kind         = kind;
    op_o.addr_m       = instr_i[3:0];
    op_o.addr_s       = instr_i[11:8];
    op_o.amt_from_reg = instr_i[4];
    op_o.sh           = somu_pkg::shift_e'(instr_i[6:5]);
    op_o.imm_amt      = instr_i[11:7];
    case (kind)
      somu_pkg::REQ_WRITE: begin
        op_o.dest    = reg_index_i;
        op_o.addr_n  = reg_index_i;
        op_o.imm_val = reg_value_i;
      end
      somu_pkg::REQ_READ: begin
        op_o.dest    = reg_index_i;
        op_o.addr_n  = reg_index_i;
        op_o.imm_val = reg_value_i;
      end
      default: begin
        op_o.dest    = instr_i[15:12];
        op_o.addr_n  = instr_i[19:16];
        op_o.imm_val = somu_pkg::rot_imm(instr_i[7:0], instr_i[11:8]);
      end
    endcase
  end

endmodule

// ===== design/somu_queue.sv =====
module somu_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  somu_pkg::op_t       push_op_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output somu_pkg::op_t       pop_op_o
);

  somu_pkg::op_t                   slot_q [somu_pkg::QDepth];
  logic [somu_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [somu_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic                            push, pop;

  assign push_ready_o = (cnt_q != somu_pkg::QCntW'(somu_pkg::QDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_op_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == somu_pkg::QPtrW'(somu_pkg::QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == somu_pkg::QPtrW'(somu_pkg::QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== design/somu_back.sv =====
`include "shifted_operand_multiply_unit_defines.svh"

module somu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  output logic                op_ready_o,
  input  somu_pkg::op_t       op_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          dest_index_o,
  output logic [31:0]         value_o
);

  localparam int W = somu_pkg::DataW;

  // Two copies of the register file: copy A serves Rn and Rm, copy B serves Rs.
  logic [W-1:0]                 rf_a_q [somu_pkg::NumRegs];
  logic [W-1:0]                 rf_b_q [somu_pkg::NumRegs];
  logic [somu_pkg::NumRegs-1:0] written_q;

  logic                         s2_valid_q, s2_valid_d;
  somu_pkg::op_t                s2_op_q;
  logic [W-1:0]                 rn_q, rm_q, rs_q;
  logic [W-1:0]                 rn_d, rm_d, rs_d;

  logic                         out_valid_q, out_valid_d;
  logic [somu_pkg::RegAw-1:0]   out_dest_q;
  logic [W-1:0]                 out_value_q;

  logic                         pop, s2_adv, we;
  logic [somu_pkg::RegAw-1:0]   wa;
  logic [W-1:0]                 wd, op2, prod;
  logic [7:0]                   amt;

  assign s2_adv     = s2_valid_q && (!out_valid_q || out_ready_i);
  assign op_ready_o = !s2_valid_q || s2_adv;
  assign pop        = op_valid_i && op_ready_o;

  // Execute
  assign amt  = s2_op_q.amt_from_reg ? rs_q[7:0] : {3'b000, s2_op_q.imm_amt};
  assign op2  = (s2_op_q.kind == somu_pkg::REQ_MUL_IMM) ? s2_op_q.imm_val
              : somu_pkg::shift_operand(rm_q, s2_op_q.sh, amt);
  assign prod = rn_q * op2;

  always_comb begin
    case (s2_op_q.kind)
      somu_pkg::REQ_WRITE: wd = s2_op_q.imm_val;
      somu_pkg::REQ_READ:  wd = rn_q;
      default:             wd = prod;
    endcase
  end

  assign we = s2_adv && (s2_op_q.kind != somu_pkg::REQ_READ);
  assign wa = s2_op_q.dest;

  // Operand reads coincide with the older request's write, so bypass it here.
  always_comb begin
    rn_d = (we && wa == op_i.addr_n) ? wd
         : (written_q[op_i.addr_n] ? rf_a_q[op_i.addr_n] : '0);
    rm_d = (we && wa == op_i.addr_m) ? wd
         : (written_q[op_i.addr_m] ? rf_a_q[op_i.addr_m] : '0);
    rs_d = (we && wa == op_i.addr_s) ? wd
         : (written_q[op_i.addr_s] ? rf_b_q[op_i.addr_s] : '0);
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (pop) begin
      s2_valid_d = 1'b1;
    end else if (s2_adv) begin
      s2_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s2_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
      if (we) begin
        written_q[wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      rf_a_q[wa] <= wd;
      rf_b_q[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s2_op_q <= op_i;
      rn_q    <= rn_d;
      rm_q    <= rm_d;
      rs_q    <= rs_d;
    end
    if (s2_adv) begin
      out_dest_q  <= s2_op_q.dest;
      out_value_q <= wd;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_index_o = out_dest_q;
  assign value_o      = out_value_q;

  `SOMU_ASSERT(a_write_marks_valid, we |=> written_q[$past(wa)], "written register not marked")
  `SOMU_ASSERT(a_adv_fills_out, s2_adv |=> out_valid_q && out_dest_q == $past(s2_op_q.dest), "result lost on its way out")
  `SOMU_ASSERT(a_stall_holds_s2, (s2_valid_q && out_valid_q && !out_ready_i) |=> s2_valid_q && $stable(s2_op_q), "stalled request moved")
  `SOMU_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> !out_valid_q && !s2_valid_q, "pipeline not empty in reset")

endmodule

// ===== design/shifted_operand_multiply_unit.sv =====
// Channel  Handshake                   Payload
// in       in_valid_i / in_ready_o     req_type_i, instr_i, reg_index_i, reg_value_i
// out      out_valid_o / out_ready_i   dest_index_o, value_o
//
// One request per cycle while out_ready_i is high; results pass queue, s2 and output registers.
// Rn, Rm and Rs are read in the pop cycle; the shift and 32x32 multiply take one stage.
// Reset clears the queue, the pipeline and the register valid bits (all registers read zero).
// A stalled output holds the execute stage; the two-entry queue keeps taking requests until full.
module shifted_operand_multiply_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   req_type_i,
  input  logic [31:0]  instr_i,
  input  logic [3:0]   reg_index_i,
  input  logic [31:0]  reg_value_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [3:0]   dest_index_o,
  output logic [31:0]  value_o
);

  somu_pkg::op_t dec_op, q_op;
  logic          q_valid, q_ready;

  somu_front u_front (
    .req_type_i  (req_type_i),
    .instr_i     (instr_i),
    .reg_index_i (reg_index_i),
    .reg_value_i (reg_value_i),
    .op_o        (dec_op)
  );

  somu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_op_i    (dec_op),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_op_o     (q_op)
  );

  somu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_valid_i   (q_valid),
    .op_ready_o   (q_ready),
    .op_i         (q_op),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dest_index_o (dest_index_o),
    .value_o      (value_o)
  );

endmodule
